FILE: hdl/umpt_pkg.sv
// Shared types, constants and helpers for the UMP tempo and division tracker.
// Used by umpt_front, umpt_queue, umpt_back and the top level.
package umpt_pkg;

  localparam int unsigned USEC_PER_MINUTE = 32'd60000000;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned TYPE_W   = 4;
  localparam int unsigned POS_W    = 2;
  localparam int unsigned REMAIN_W = 2;

  localparam int unsigned REG_IDX_W = 1;

  localparam logic [VALUE_W-1:0] DIVISION_RESET = 16'd480;
  localparam logic [VALUE_W-1:0] BPM_RESET      = 16'd120;

  localparam logic [TYPE_W-1:0] TYPE_DATA128 = 4'h5;
  localparam logic [TYPE_W-1:0] TYPE_FLEX    = 4'hD;
  localparam logic [TYPE_W-1:0] TYPE_STREAM  = 4'hF;
  localparam logic [TYPE_W-1:0] TYPE_SYSEX7  = 4'h3;
  localparam logic [TYPE_W-1:0] TYPE_CV2     = 4'h4;

  localparam int unsigned DVD_W     = $clog2(USEC_PER_MINUTE + 1);
  localparam int unsigned DIV_STEPS = (DVD_W + 1) / 2;
  localparam int unsigned DVD_PAD_W = 2 * DIV_STEPS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DIVISION_AT_START = 1'b0,
    REG_BPM_AT_START      = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_DIV   = 2'd1,
    OP_TEMPO = 2'd2
  } op_e;

  typedef struct packed {
    logic               start;
    op_e                op;
    logic [WORD_W-1:0]  operand;
    logic [TYPE_W-1:0]  mtype;
    logic [POS_W-1:0]   pos;
    logic               done;
  } entry_t;

  typedef struct packed {
    logic [VALUE_W-1:0] division;
    logic [VALUE_W-1:0] bpm;
    logic [TYPE_W-1:0]  mtype;
    logic [POS_W-1:0]   pos;
    logic               done;
    logic               changed;
  } result_t;

  function automatic logic [REMAIN_W-1:0] extra_words(input logic [TYPE_W-1:0] t);
    logic [REMAIN_W-1:0] n;
    case (t)
      TYPE_SYSEX7, TYPE_CV2:             n = 2'd1;
      TYPE_DATA128, TYPE_FLEX, TYPE_STREAM: n = 2'd3;
      default:                           n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/umpt_front.sv
// Front end: accepts packet words, frames them into messages and classifies
// each word into a queue entry. Depends on umpt_pkg.
module umpt_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [umpt_pkg::WORD_W-1:0]   word_i,
  input  logic                          start_i,
  output logic                          push_o,
  output umpt_pkg::entry_t              entry_o,
  input  logic                          full_i
);
  import umpt_pkg::*;

  logic [REMAIN_W-1:0] remain_q, remain_d, remain_eff;
  logic [TYPE_W-1:0]   type_q, type_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                hsz_q, hsz_d;
  logic [WORD_W-1:0]   sw_q, sw_d;
  logic                done;
  op_e                 op;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign remain_eff = start_i ? '0 : remain_q;

  always_comb begin
    type_d   = type_q;
    pos_d    = pos_q;
    hsz_d    = hsz_q;
    sw_d     = sw_q;
    remain_d = remain_q;
    done     = 1'b0;
    op       = OP_NONE;
    if (remain_eff == '0) begin
      type_d = word_i[31:28];
      pos_d  = '0;
      case (type_d)
        TYPE_STREAM: hsz_d = (word_i[25:16] == '0);
        TYPE_FLEX:   hsz_d = (word_i[7:0] == '0);
        default:     hsz_d = 1'b0;
      endcase
      remain_d = extra_words(type_d);
      done     = (remain_d == '0);
    end else begin
      pos_d = pos_q + POS_W'(1);
      if (pos_d == POS_W'(1)) begin
        sw_d = word_i;
      end
      remain_d = remain_eff - REMAIN_W'(1);
      if (remain_d == '0) begin
        done = 1'b1;
        if (hsz_q && type_q == TYPE_STREAM) begin
          op = OP_DIV;
        end else if (hsz_q && type_q == TYPE_FLEX && sw_d != '0) begin
          op = OP_TEMPO;
        end
      end
    end
  end

  always_comb begin
    entry_o.start   = start_i;
    entry_o.op      = op;
    entry_o.operand = sw_d;
    entry_o.mtype   = type_d;
    entry_o.pos     = pos_d;
    entry_o.done    = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      type_q   <= '0;
      pos_q    <= '0;
      hsz_q    <= 1'b0;
      sw_q     <= '0;
    end else if (push_o) begin
      remain_q <= remain_d;
      type_q   <= type_d;
      pos_q    <= pos_d;
      hsz_q    <= hsz_d;
      sw_q     <= sw_d;
    end
  end

`ifndef SYNTHESIS
  a_op_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && entry_o.op != OP_NONE |-> entry_o.done)
    else $error("update op on a word that does not complete its message");
`endif

endmodule

FILE: hdl/umpt_queue.sv
// Short queue of classified entries between front and back end.
// Depends on umpt_pkg.
module umpt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  umpt_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output umpt_pkg::entry_t pop_data_o,
  output logic             empty_o
);
  import umpt_pkg::*;

  entry_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

FILE: hdl/umpt_back.sv
// Back end: holds start registers, division and tempo, runs the radix-4 tempo
// divider and drives the registered result item. Depends on umpt_pkg.
module umpt_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [umpt_pkg::REG_IDX_W-1:0]      cfg_addr_i,
  input  logic [umpt_pkg::VALUE_W-1:0]        cfg_wdata_i,
  input  logic                                empty_i,
  input  umpt_pkg::entry_t                    entry_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output umpt_pkg::result_t                   result_o
);
  import umpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } back_state_e;

  back_state_e             state_q, state_d;
  logic [VALUE_W-1:0]      cfg_div_q, cfg_bpm_q;
  logic [VALUE_W-1:0]      div_q, div_d, bpm_q, bpm_d;
  logic [VALUE_W-1:0]      div_base, bpm_base;
  entry_t                  hold_q, hold_d;
  logic [WORD_W-1:0]       rem_q, rem_d, dsr_q, dsr_d;
  logic [DVD_PAD_W-1:0]    dvd_q, dvd_d;
  logic [VALUE_W-1:0]      quo_q, quo_d;
  logic [DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [WORD_W:0]         r1, r2;
  logic [WORD_W-1:0]       r1s, r2s;
  logic                    ge1, ge2;
  logic                    out_free, load_out;
  logic                    out_valid_q, out_valid_d;
  result_t                 res_q, res_d;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign pop_o       = (state_q == S_IDLE) && !empty_i && out_free;
  assign div_base    = entry_i.start ? cfg_div_q : div_q;
  assign bpm_base    = entry_i.start ? cfg_bpm_q : bpm_q;

  always_comb begin
    r1  = {rem_q, dvd_q[DVD_PAD_W-1]};
    ge1 = (r1 >= {1'b0, dsr_q});
    r1s = ge1 ? WORD_W'(r1 - {1'b0, dsr_q}) : r1[WORD_W-1:0];
    r2  = {r1s, dvd_q[DVD_PAD_W-2]};
    ge2 = (r2 >= {1'b0, dsr_q});
    r2s = ge2 ? WORD_W'(r2 - {1'b0, dsr_q}) : r2[WORD_W-1:0];
  end

  always_comb begin
    state_d  = state_q;
    div_d    = div_q;
    bpm_d    = bpm_q;
    hold_d   = hold_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    load_out = 1'b0;
    res_d    = res_q;
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          div_d         = div_base;
          bpm_d         = bpm_base;
          res_d.mtype   = entry_i.mtype;
          res_d.pos     = entry_i.pos;
          res_d.done    = entry_i.done;
          res_d.changed = 1'b0;
          case (entry_i.op)
            OP_DIV: begin
              div_d         = entry_i.operand[31:16];
              res_d.changed = 1'b1;
              load_out      = 1'b1;
            end
            OP_TEMPO: begin
              hold_d  = entry_i;
              rem_d   = '0;
              dsr_d   = entry_i.operand;
              dvd_d   = DVD_PAD_W'(USEC_PER_MINUTE);
              quo_d   = '0;
              cnt_d   = DIV_CNT_W'(DIV_STEPS - 1);
              state_d = S_DIV;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
          res_d.division = div_d;
          res_d.bpm      = bpm_d;
        end
      end
      S_DIV: begin
        rem_d = r2s;
        dvd_d = {dvd_q[DVD_PAD_W-3:0], 2'b00};
        quo_d = {quo_q[VALUE_W-3:0], ge1, ge2};
        cnt_d = cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          bpm_d          = quo_q;
          res_d.division = div_q;
          res_d.bpm      = quo_q;
          res_d.mtype    = hold_q.mtype;
          res_d.pos      = hold_q.pos;
          res_d.done     = hold_q.done;
          res_d.changed  = 1'b1;
          load_out       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_div_q <= DIVISION_RESET;
      cfg_bpm_q <= BPM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DIVISION_AT_START: cfg_div_q <= cfg_wdata_i;
        REG_BPM_AT_START:      cfg_bpm_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_q       <= DIVISION_RESET;
      bpm_q       <= BPM_RESET;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      div_q       <= div_d;
      bpm_q       <= bpm_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    if (load_out) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !pop_o)
    else $error("entry popped while divide in progress");
  a_changed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.changed |-> res_q.done)
    else $error("update reported on a word that does not complete its message");
`endif

endmodule

FILE: hdl/ump_stream_tempo_division_tracker_top.sv
// Top level of the UMP stream tempo and division tracker.
// Instantiates umpt_front, umpt_queue and umpt_back; depends on umpt_pkg.
//
//   channel  dir  payload
//   s_axis   in   tdata = ump_word[31:0]; tuser = stream_start
//   m_axis   out  tdata = division, bpm, message_type, word_position, pad;
//                 tlast = message_done; tuser = value_changed
//   cfg      in   cfg_addr_i 0 = division_at_start, 1 = bpm_at_start
//
// In the back end a word that completes a tempo message takes a load step, 13 radix-4
// steps of the shared divider and a result step; no new word is taken while a divide
// runs. A two-entry queue lets the front take words during a divide.
// Reset clears framing and loads division 480 and tempo 120.
// A stalled m_axis holds the result register; the queue then fills and
// s_axis_tready_o drops.
module ump_stream_tempo_division_tracker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [31:0]                        s_axis_tdata_i,  // ump_word
  input  logic                               s_axis_tuser_i,  // stream_start
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // division[15:0], bpm[31:16], message_type[35:32], word_position[37:36], zero[39:38]
  output logic [39:0]                        m_axis_tdata_o,
  output logic                               m_axis_tlast_o,  // message_done
  output logic                               m_axis_tuser_o,  // value_changed
  input  logic                               cfg_we_i,
  input  logic [umpt_pkg::REG_IDX_W-1:0]     cfg_addr_i,
  input  logic [umpt_pkg::VALUE_W-1:0]       cfg_wdata_i
);
  import umpt_pkg::*;

  entry_t  push_entry, pop_entry;
  logic    push, pop, full, empty;
  result_t result;

  umpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .word_i     (s_axis_tdata_i),
    .start_i    (s_axis_tuser_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  umpt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .empty_o     (empty)
  );

  umpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  assign m_axis_tdata_o = {2'b00, result.pos, result.mtype, result.bpm, result.division};
  assign m_axis_tlast_o = result.done;
  assign m_axis_tuser_o = result.changed;

endmodule

FILE: verif/tempo_division_checker.sv
// Checker for the UMP tempo and division tracker: watches the item, result and register
// write channels, tracks framing, division and tempo itself, and compares every result.
// Depends on umpt_pkg for the register indexes, type codes and the result layout.
module tempo_division_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [31:0]                    s_tdata_i,
  input  logic                           s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [39:0]                    m_tdata_i,
  input  logic                           m_tlast_i,
  input  logic                           m_tuser_i,
  input  logic                           cfg_we_i,
  input  logic [umpt_pkg::REG_IDX_W-1:0] cfg_addr_i,
  input  logic [umpt_pkg::VALUE_W-1:0]   cfg_wdata_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             results_o,
  output int                             updates_o
);
  import umpt_pkg::*;

  logic [VALUE_W-1:0]  division_init = DIVISION_RESET;
  logic [VALUE_W-1:0]  tempo_init    = BPM_RESET;
  logic [REMAIN_W-1:0] frame_left    = '0;
  logic [TYPE_W-1:0]   frame_type    = '0;
  logic [POS_W-1:0]    frame_pos     = '0;
  logic                hdr_zero      = 1'b0;
  logic [WORD_W-1:0]   payload_word  = '0;
  logic [VALUE_W-1:0]  division_now  = DIVISION_RESET;
  logic [VALUE_W-1:0]  tempo_now     = BPM_RESET;

  result_t expected_results[$];
  int      words_in   = 0;
  int      fail_count = 0;
  int      results    = 0;
  int      updates    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = words_in - results;
  assign results_o    = results;
  assign updates_o    = updates;

  task automatic track_word(input logic [WORD_W-1:0] w, input logic st, output result_t r);
    logic              done;
    logic              changed;
    logic [WORD_W-1:0] quotient;
    done    = 1'b0;
    changed = 1'b0;
    if (st) begin
      frame_left   = '0;
      division_now = division_init;
      tempo_now    = tempo_init;
    end
    if (frame_left == '0) begin
      frame_type = w[31:28];
      frame_pos  = '0;
      case (frame_type)
        TYPE_STREAM: hdr_zero = (w[25:16] == '0);
        TYPE_FLEX:   hdr_zero = (w[7:0] == '0);
        default:     hdr_zero = 1'b0;
      endcase
      case (frame_type)
        TYPE_SYSEX7, TYPE_CV2:                frame_left = 2'd1;
        TYPE_DATA128, TYPE_FLEX, TYPE_STREAM: frame_left = 2'd3;
        default:                              frame_left = 2'd0;
      endcase
      done = (frame_left == '0);
    end else begin
      frame_pos = frame_pos + 2'd1;
      if (frame_pos == 2'd1) payload_word = w;
      frame_left = frame_left - 2'd1;
      if (frame_left == '0) begin
        done = 1'b1;
        if (hdr_zero && frame_type == TYPE_STREAM) begin
          division_now = payload_word[31:16];
          changed      = 1'b1;
        end else if (hdr_zero && frame_type == TYPE_FLEX && payload_word != '0) begin
          quotient  = USEC_PER_MINUTE / payload_word;
          tempo_now = quotient[VALUE_W-1:0];
          changed   = 1'b1;
        end
      end
    end
    r.division = division_now;
    r.bpm      = tempo_now;
    r.mtype    = frame_type;
    r.pos      = frame_pos;
    r.done     = done;
    r.changed  = changed;
  endtask

  function automatic int field_bad(input string name, input logic [15:0] want,
                                   input logic [15:0] got);
    if (want === got) return 0;
    $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t next_exp;
    result_t want;
    int      errs;
    errs = 0;
    if (!rst_ni) begin
      division_init = DIVISION_RESET;
      tempo_init    = BPM_RESET;
      frame_left    = '0;
      frame_type    = '0;
      frame_pos     = '0;
      hdr_zero      = 1'b0;
      payload_word  = '0;
      division_now  = division_init;
      tempo_now     = tempo_init;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_DIVISION_AT_START: division_init = cfg_wdata_i;
          REG_BPM_AT_START:      tempo_init    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        track_word(s_tdata_i, s_tuser_i, next_exp);
        expected_results.push_back(next_exp);
        words_in <= words_in + 1;
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual %0h", $time, m_tdata_i);
          errs = 1;
        end else begin
          want = expected_results.pop_front();
          errs += field_bad("division", want.division, m_tdata_i[15:0]);
          errs += field_bad("bpm", want.bpm, m_tdata_i[31:16]);
          errs += field_bad("message_type", 16'(want.mtype), 16'(m_tdata_i[35:32]));
          errs += field_bad("word_position", 16'(want.pos), 16'(m_tdata_i[37:36]));
          errs += field_bad("pad", 16'd0, 16'(m_tdata_i[39:38]));
          errs += field_bad("message_done", 16'(want.done), 16'(m_tlast_i));
          errs += field_bad("value_changed", 16'(want.changed), 16'(m_tuser_i));
          if (want.changed) updates <= updates + 1;
          results <= results + 1;
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

FILE: verif/testbench.sv
// Top of the tracker regression: clock, reset, item and register-write stimulus,
// receiver back-pressure and the verdict. Depends on umpt_pkg, the block and
// tempo_division_checker, which predicts and compares.
module testbench;
  import umpt_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TOTAL_WORDS  = 1950;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [31:0]          s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tready = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = REG_DIVISION_AT_START;
  logic [VALUE_W-1:0]   cfg_wdata = '0;

  logic        s_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  int fail_count;
  int pending;
  int results;
  int updates;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles    = 0;
  int words_sent = 0;
  int dir_words  = 0;
  int settings   = 1;
  bit next_start = 1'b0;

  ump_stream_tempo_division_tracker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  tempo_division_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .m_tuser_i    (m_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .updates_o    (updates)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("ump_stream_tempo_division_tracker_top regression: fail");
      $finish;
    end
  end

  // Hold off the receiver for a long stretch on request, else idle at random.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_word(input logic [31:0] w, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tuser  <= st;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_msg(input logic st, input int n, input logic [31:0] w0,
                          input logic [31:0] w1, input logic [31:0] w2,
                          input logic [31:0] w3);
    logic [31:0] words [4];
    words = '{w0, w1, w2, w3};
    for (int i = 0; i < n; i++) push_word(words[i], (i == 0) ? st : 1'b0);
  endtask

  task automatic write_starts(input logic [VALUE_W-1:0] div, input logic [VALUE_W-1:0] bpm);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_DIVISION_AT_START;
    cfg_wdata <= div;
    @(posedge clk_i);
    cfg_addr  <= REG_BPM_AT_START;
    cfg_wdata <= bpm;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings++;
    next_start = 1'b1;
  endtask

  task automatic random_message();
    int          kind;
    int          n;
    logic [31:0] h;
    logic [31:0] p;
    logic [3:0]  t;
    logic        st;
    kind = $urandom_range(99);
    st = next_start || ($urandom_range(19) == 0);
    next_start = 1'b0;
    h = $urandom;
    p = $urandom;
    if (kind < 30) begin
      h[31:28] = TYPE_FLEX;
      if ($urandom_range(4) != 0) h[7:0] = '0;
      case ($urandom_range(5))
        0:       p = $urandom_range(1000);
        1:       p = 32'hFFFF_FFFF;
        2, 3:    p = $urandom_range(2000000, 200000);
        default: ;
      endcase
      send_msg(st, 4, h, p, $urandom, $urandom);
    end else if (kind < 55) begin
      h[31:28] = TYPE_STREAM;
      if ($urandom_range(4) != 0) h[25:16] = '0;
      send_msg(st, 4, h, p, $urandom, $urandom);
    end else if (kind < 65) begin
      h[31:28] = TYPE_DATA128;
      send_msg(st, 4, h, p, $urandom, $urandom);
    end else if (kind < 75) begin
      h[31:28] = $urandom_range(1) ? TYPE_SYSEX7 : TYPE_CV2;
      send_msg(st, 2, h, p, '0, '0);
    end else if (kind < 88) begin
      t = 4'($urandom_range(15));
      while (t inside {TYPE_SYSEX7, TYPE_CV2, TYPE_DATA128, TYPE_FLEX, TYPE_STREAM})
        t = 4'($urandom_range(15));
      h[31:28] = t;
      push_word(h, st);
    end else if (kind < 94) begin
      // cut the message short; the next one opens a new stream
      case ($urandom_range(2))
        0:       begin h[31:28] = TYPE_FLEX; h[7:0] = '0; end
        1:       begin h[31:28] = TYPE_STREAM; h[25:16] = '0; end
        default: h[31:28] = TYPE_DATA128;
      endcase
      n = $urandom_range(3, 1);
      send_msg(st, n, h, p, $urandom, $urandom);
      next_start = 1'b1;
    end else begin
      push_word($urandom, ($urandom_range(3) == 0));
    end
  endtask

  initial begin
    send_idle_pct = 18;
    recv_idle_pct = 67;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset values, framing of each length, updates and their exceptions
    push_word({4'h0, 28'h0000000}, 1'b0);
    send_msg(1'b0, 2, {TYPE_SYSEX7, 28'h1234567}, 32'h89AB_CDEF, '0, '0);
    push_word({4'h7, 28'h1234567}, 1'b0);
    send_msg(1'b0, 4, {TYPE_STREAM, 28'h0000000}, 32'hFFFF_0000, '0, '0);
    send_msg(1'b0, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_msg(1'b0, 4, {TYPE_FLEX, 28'h0000000}, 32'h0000_0001, '0, '0);
    send_msg(1'b0, 4, {TYPE_FLEX, 28'hFFFFF00}, 32'h0000_0000, '0, '0);
    send_msg(1'b0, 2, {TYPE_FLEX, 28'h0000000}, 32'd500000, '0, '0);
    push_word({4'h2, 28'hABCDEF0}, 1'b1);
    dir_words = words_sent;

    write_starts(16'hFFFF, 16'h0000);
    while (words_sent < dir_words + 650) random_message();

    send_idle_pct = 67;
    recv_idle_pct = 18;
    write_starts(16'h0000, 16'hFFFF);
    while (words_sent < dir_words + 1300) random_message();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_starts(16'($urandom), 16'($urandom));
    hold_req <= hold_req + 1;
    while (words_sent < TOTAL_WORDS) random_message();

    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d words (%0d directed), %0d results checked, %0d value updates",
             words_sent, dir_words, results, updates);
    $display("over three idling mixes, %0d register settings and one long output stall",
             settings);
    if (fail_count == 0) begin
      $display("ump_stream_tempo_division_tracker_top regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("ump_stream_tempo_division_tracker_top regression: fail");
    end
    $finish;
  end

endmodule
